FILE: hdl/hrrn_pkg.sv
// Shared types and constants of the response-ratio entry selector.
package hrrn_pkg;

    // Round capacity and derived widths
    localparam int MAX_READY = 64;
    localparam int COUNT_W   = $clog2(MAX_READY + 1);
    localparam int INDEX_W   = 6;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int ALPHA_W = 9;
    localparam int EST_W   = 41;

    // Q1.8 unity weight
    localparam logic [ALPHA_W-1:0] Q8_ONE = 9'd256;

    // Serial step counts: one alpha bit per step, one wait bit per step
    localparam int EST_STEPS  = ALPHA_W;
    localparam int EST_CNT_W  = $clog2(EST_STEPS + 1);
    localparam int CMP_STEPS  = TIME_W;
    localparam int CMP_CNT_W  = $clog2(CMP_STEPS + 1);
    localparam int CMP_ACC_W  = TIME_W + EST_W + 2;
    localparam int TERM_W     = EST_W + 1;

    typedef struct packed {
        logic [TIME_W-1:0] arrival_ms;
        logic [TIME_W-1:0] now_ms;
        logic [TIME_W-1:0] prev_estimate_ms;
        logic [TIME_W-1:0] prev_burst_ms;
        logic              last_entry;
    } in_t;

    typedef struct packed {
        logic [INDEX_W-1:0] chosen_index;
        logic               overflowed;
    } out_t;

    // Estimate unit request and response
    typedef struct packed {
        logic               start;
        logic [ALPHA_W-1:0] alpha;
        logic [TIME_W-1:0]  prev_est;
        logic [TIME_W-1:0]  prev_burst;
    } est_req_t;

    typedef struct packed {
        logic             done;
        logic [EST_W-1:0] est;
    } est_rsp_t;

    // Ratio compare request and response
    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] cw;
        logic [EST_W-1:0]  ce;
        logic [TIME_W-1:0] bw;
        logic [EST_W-1:0]  be;
    } cmp_req_t;

    typedef struct packed {
        logic done;
        logic not_less;
    } cmp_rsp_t;

endpackage

FILE: hdl/hrrn_est_serial.sv
// Bit-serial exponential average: prev_est*a + prev_burst*(256-a), MSB first.
module hrrn_est_serial (
    input  logic               aclk,
    input  logic               aresetn,
    input  hrrn_pkg::est_req_t req,
    output hrrn_pkg::est_rsp_t rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [hrrn_pkg::EST_CNT_W-1:0]      cnt_reg;
    logic [hrrn_pkg::ALPHA_W-1:0]        a_sh_reg;
    logic [hrrn_pkg::ALPHA_W-1:0]        b_sh_reg;
    logic [hrrn_pkg::TIME_W-1:0]         pe_reg;
    logic [hrrn_pkg::TIME_W-1:0]         pb_reg;
    logic [hrrn_pkg::TIME_W:0]           sum_reg;
    logic [hrrn_pkg::EST_W-1:0]          acc_reg;
    logic [hrrn_pkg::EST_W-1:0]          acc_next;
    logic [hrrn_pkg::ALPHA_W-1:0]        a_eff;
    logic [hrrn_pkg::ALPHA_W-1:0]        b_eff;
    logic [hrrn_pkg::TIME_W:0]           sel;

    // Alpha above one is used as one
    always_comb begin
        a_eff = (req.alpha > hrrn_pkg::Q8_ONE) ? hrrn_pkg::Q8_ONE : req.alpha;
        b_eff = hrrn_pkg::Q8_ONE - a_eff;
    end

    // Pick the addend for the current weight bits
    always_comb begin
        case ({a_sh_reg[hrrn_pkg::ALPHA_W-1], b_sh_reg[hrrn_pkg::ALPHA_W-1]})
            2'b10:   sel = {1'b0, pe_reg};
            2'b01:   sel = {1'b0, pb_reg};
            2'b11:   sel = sum_reg;
            default: sel = '0;
        endcase
        acc_next = {acc_reg[hrrn_pkg::EST_W-2:0], 1'b0}
                   + hrrn_pkg::EST_W'(sel);
    end

    // Step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= hrrn_pkg::EST_CNT_W'(hrrn_pkg::EST_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == hrrn_pkg::EST_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: shift weights, accumulate
    always_ff @(posedge aclk) begin
        if (req.start) begin
            a_sh_reg <= a_eff;
            b_sh_reg <= b_eff;
            pe_reg   <= req.prev_est;
            pb_reg   <= req.prev_burst;
            sum_reg  <= {1'b0, req.prev_est} + {1'b0, req.prev_burst};
            acc_reg  <= '0;
        end else if (busy_reg) begin
            a_sh_reg <= {a_sh_reg[hrrn_pkg::ALPHA_W-2:0], 1'b0};
            b_sh_reg <= {b_sh_reg[hrrn_pkg::ALPHA_W-2:0], 1'b0};
            acc_reg  <= acc_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.est  = acc_reg;

endmodule

FILE: hdl/hrrn_ratio_cmp.sv
// Bit-serial cross-multiply compare: sign of cw*be - bw*ce, MSB first over the waits.
module hrrn_ratio_cmp (
    input  logic               aclk,
    input  logic               aresetn,
    input  hrrn_pkg::cmp_req_t req,
    output hrrn_pkg::cmp_rsp_t rsp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [hrrn_pkg::CMP_CNT_W-1:0]      cnt_reg;
    logic [hrrn_pkg::TIME_W-1:0]         cw_sh_reg;
    logic [hrrn_pkg::TIME_W-1:0]         bw_sh_reg;
    logic signed [hrrn_pkg::TERM_W-1:0]  be_reg;
    logic signed [hrrn_pkg::TERM_W-1:0]  nce_reg;
    logic signed [hrrn_pkg::TERM_W-1:0]  diff_reg;
    logic signed [hrrn_pkg::CMP_ACC_W-1:0] acc_reg;
    logic signed [hrrn_pkg::CMP_ACC_W-1:0] acc_next;
    logic signed [hrrn_pkg::TERM_W-1:0]  term;
    logic signed [hrrn_pkg::TERM_W-1:0]  be_ext;
    logic signed [hrrn_pkg::TERM_W-1:0]  ce_ext;

    assign be_ext = {1'b0, req.be};
    assign ce_ext = {1'b0, req.ce};

    // Per-bit term: +be for a candidate wait bit, -ce for a best wait bit
    always_comb begin
        case ({cw_sh_reg[hrrn_pkg::TIME_W-1], bw_sh_reg[hrrn_pkg::TIME_W-1]})
            2'b10:   term = be_reg;
            2'b01:   term = nce_reg;
            2'b11:   term = diff_reg;
            default: term = '0;
        endcase
        acc_next = {acc_reg[hrrn_pkg::CMP_ACC_W-2:0], 1'b0}
                   + hrrn_pkg::CMP_ACC_W'(term);
    end

    // Step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= hrrn_pkg::CMP_CNT_W'(hrrn_pkg::CMP_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == hrrn_pkg::CMP_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            cw_sh_reg <= req.cw;
            bw_sh_reg <= req.bw;
            be_reg    <= be_ext;
            nce_reg   <= -ce_ext;
            diff_reg  <= be_ext - ce_ext;
            acc_reg   <= '0;
        end else if (busy_reg) begin
            cw_sh_reg <= {cw_sh_reg[hrrn_pkg::TIME_W-2:0], 1'b0};
            bw_sh_reg <= {bw_sh_reg[hrrn_pkg::TIME_W-2:0], 1'b0};
            acc_reg   <= acc_next;
        end
    end

    // Not less when the difference is non-negative
    assign rsp.done     = done_reg;
    assign rsp.not_less = ~acc_reg[hrrn_pkg::CMP_ACC_W-1];

endmodule

FILE: hdl/hrrn_ready_entry_selector.sv
// Top level: highest-response-ratio selector over a streamed round of ready entries.
// Flow: one entry at a time; each entry's time is set by the bit-serial
//   compare (32 steps, one wait bit each) after the 9-step serial estimate; the first
//   entry of a round skips the compare, and an entry past capacity skips both units.
// Output: the result is registered on m_data from the finish state after the last entry's work ends;
//   a pending result is held until taken, stalling the input.
// Reset (aresetn, synchronous, active low): round state cleared, alpha_reg set to 128.
module hrrn_ready_entry_selector (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  hrrn_pkg::in_t                   s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output hrrn_pkg::out_t                  m_data,
    input  logic                            cfg_wr_en,
    input  logic [hrrn_pkg::ALPHA_W-1:0]    cfg_wr_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EST,
        S_CMP,
        S_FIN
    } state_t;

    state_t                           state_reg;
    logic [hrrn_pkg::ALPHA_W-1:0]     alpha_reg;
    logic [hrrn_pkg::TIME_W-1:0]      best_wait_reg;
    logic [hrrn_pkg::EST_W-1:0]       best_est_reg;
    logic [hrrn_pkg::INDEX_W-1:0]     best_pos_reg;
    logic [hrrn_pkg::COUNT_W-1:0]     count_reg;
    logic                             overflow_reg;
    logic [hrrn_pkg::TIME_W-1:0]      cand_wait_reg;
    logic [hrrn_pkg::EST_W-1:0]       cand_est_reg;
    logic                             last_reg;
    logic                             m_valid_reg;
    hrrn_pkg::out_t                   m_data_reg;

    logic                             s_fire;
    logic                             has_room;
    logic                             emit;
    logic [hrrn_pkg::TIME_W-1:0]      wait_in;
    logic [hrrn_pkg::EST_W-1:0]       est_fix;
    logic [hrrn_pkg::INDEX_W-1:0]     pos_now;
    hrrn_pkg::est_req_t               est_req;
    hrrn_pkg::est_rsp_t               est_rsp;
    hrrn_pkg::cmp_req_t               cmp_req;
    hrrn_pkg::cmp_rsp_t               cmp_rsp;

    assign s_ready  = (state_reg == S_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign has_room = (count_reg < hrrn_pkg::COUNT_W'(hrrn_pkg::MAX_READY));
    assign pos_now  = hrrn_pkg::INDEX_W'(count_reg);

    // Result load: last entry finished and the output register is free
    assign emit = (state_reg == S_FIN) && last_reg && (!m_valid_reg || m_ready);

    // Wait clamped at zero when now is before arrival
    assign wait_in = (s_data.now_ms > s_data.arrival_ms)
                   ? (s_data.now_ms - s_data.arrival_ms) : '0;

    // Zero wait over zero estimate counts as ratio zero (estimate taken as one)
    assign est_fix = ((est_rsp.est == '0) && (cand_wait_reg == '0))
                   ? hrrn_pkg::EST_W'(1) : est_rsp.est;

    // Estimate unit launch
    always_comb begin
        est_req.start      = s_fire && has_room;
        est_req.alpha      = alpha_reg;
        est_req.prev_est   = s_data.prev_estimate_ms;
        est_req.prev_burst = s_data.prev_burst_ms;
    end

    // Compare launch once the estimate is in and a best entry exists
    always_comb begin
        cmp_req.start = (state_reg == S_EST) && est_rsp.done && (count_reg != '0);
        cmp_req.cw    = cand_wait_reg;
        cmp_req.ce    = est_fix;
        cmp_req.bw    = best_wait_reg;
        cmp_req.be    = best_est_reg;
    end

    hrrn_est_serial u_est (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (est_req),
        .rsp     (est_rsp)
    );

    hrrn_ratio_cmp u_cmp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (cmp_req),
        .rsp     (cmp_rsp)
    );

    // Control, round state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            alpha_reg     <= 9'd128;
            best_wait_reg <= '0;
            best_est_reg  <= '0;
            best_pos_reg  <= '0;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                alpha_reg <= cfg_wr_data;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_fire) begin
                        cand_wait_reg <= wait_in;
                        last_reg      <= s_data.last_entry;
                        if (has_room) begin
                            state_reg <= S_EST;
                        end else begin
                            overflow_reg <= 1'b1;
                            state_reg    <= S_FIN;
                        end
                    end
                end
                S_EST: begin
                    if (est_rsp.done) begin
                        if (count_reg == '0) begin
                            best_wait_reg <= cand_wait_reg;
                            best_est_reg  <= est_fix;
                            best_pos_reg  <= pos_now;
                            count_reg     <= count_reg + 1'b1;
                            state_reg     <= S_FIN;
                        end else begin
                            cand_est_reg <= est_fix;
                            state_reg    <= S_CMP;
                        end
                    end
                end
                S_CMP: begin
                    if (cmp_rsp.done) begin
                        if (cmp_rsp.not_less) begin
                            best_wait_reg <= cand_wait_reg;
                            best_est_reg  <= cand_est_reg;
                            best_pos_reg  <= pos_now;
                        end
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!last_reg) begin
                        state_reg <= S_IDLE;
                    end else if (emit) begin
                        m_data_reg.chosen_index <= best_pos_reg;
                        m_data_reg.overflowed   <= overflow_reg;
                        best_wait_reg <= '0;
                        best_est_reg  <= '0;
                        best_pos_reg  <= '0;
                        count_reg     <= '0;
                        overflow_reg  <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Unit responses only arrive in the state waiting on them
    a_est_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        est_rsp.done |-> (state_reg == S_EST))
        else $error("estimate done outside estimate state");

    a_cmp_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_rsp.done |-> (state_reg == S_CMP))
        else $error("compare done outside compare state");

    // Overflow only once the round is full
    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> (count_reg == hrrn_pkg::COUNT_W'(hrrn_pkg::MAX_READY)))
        else $error("overflow flagged before round is full");

    // An accepted transaction always leaves idle
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg != S_IDLE))
        else $error("accepted transaction not processed");

endmodule
